>>> rtl/vsdf_pkg.sv
// Package for the voxel signed-distance query core.
// Holds sizes, opcode and register codes, and the sequencer state type.
package vsdf_pkg;
   localparam int MaxDim = 32;
   localparam int FracBits = 8;
   localparam int IdxW = $clog2(MaxDim);
   localparam int AddrW = 3 * IdxW;
   localparam int CoordW = 14;
   localparam int DimW = 6;
   localparam int DistW = 16;
   localparam int MatW = 8;
   localparam int GradW = 17;
   localparam int SmpW = 18;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      REG_DIM_X = 2'd0,
      REG_DIM_Y = 2'd1,
      REG_DIM_Z = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LERP,
      ST_MAT,
      ST_DONE
   } state_type;
endpackage

>>> rtl/voxel_sdf_trilinear_gradient_query_core.sv
// Top level of the voxel signed-distance query core.
// Depends on vsdf_pkg. Holds the distance and material memories and the sequencer.
//
//   channel | direction | handshake
//   req_    | in        | req_valid / req_stall
//   rsp_    | out       | rsp_valid / rsp_stall
//   csr_    | in        | csr_write_enable, no read-back
//
// A write transaction stores a voxel and gives no response. A query inside the
// grid takes seven samples of eight corner reads each through the single read port
// of the distance memory, each followed by its lerp steps, then the last gradient
// and the material read, and then publishes; one outside gets an invalid result.
// Reset clears control state and sets dims to 32; memories are not cleared.
// A result waits in the output register under stall, and the next transaction
// is taken only once the result has gone.
module voxel_sdf_trilinear_gradient_query_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_opcode,
   input  logic [vsdf_pkg::CoordW-1:0]     req_coord_x,
   input  logic [vsdf_pkg::CoordW-1:0]     req_coord_y,
   input  logic [vsdf_pkg::CoordW-1:0]     req_coord_z,
   input  logic signed [vsdf_pkg::DistW-1:0] req_write_distance,
   input  logic [vsdf_pkg::MatW-1:0]       req_write_material,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_valid_res,
   output logic signed [vsdf_pkg::DistW-1:0] rsp_distance,
   output logic signed [vsdf_pkg::GradW-1:0] rsp_grad_x,
   output logic signed [vsdf_pkg::GradW-1:0] rsp_grad_y,
   output logic signed [vsdf_pkg::GradW-1:0] rsp_grad_z,
   output logic signed [vsdf_pkg::MatW:0]  rsp_material,
   input  logic                            csr_write_enable,
   input  logic [1:0]                      csr_index,
   input  logic [vsdf_pkg::DimW-1:0]       csr_write_data
);
   import vsdf_pkg::*;

   localparam int PW = CoordW + 2;   // signed sample coordinate
   localparam logic signed [PW-1:0] One = PW'(1 << FracBits);

   logic [DistW-1:0] dist_mem [2**AddrW];
   logic [MatW-1:0]  mat_mem  [2**AddrW];

   logic [DimW-1:0] dim_x_ff, dim_y_ff, dim_z_ff;
   state_type state_ff, state_in;
   logic [2:0] smp_ff, smp_in;       // sample number 0..6
   logic [2:0] crn_ff, crn_in;       // corner number
   logic [2:0] stp_ff, stp_in;       // step number in the lerp and material states
   logic [CoordW-1:0] cx_ff, cy_ff, cz_ff;
   logic signed [DistW-1:0] crn_val_ff [8];
   logic signed [DistW-1:0] lv_ff [7];
   logic signed [SmpW-1:0] s0_ff, sa_ff, ga_ff, gb_ff, gc_ff;
   logic rd_pend_ff;
   logic [AddrW-1:0] rd_addr;
   logic [DistW-1:0] rd_data_ff;
   logic [MatW-1:0] mat_data_ff;
   logic rsp_valid_ff;
   logic vres_ff;
   logic signed [DistW-1:0] odist_ff;
   logic signed [GradW-1:0] ogx_ff, ogy_ff, ogz_ff;
   logic signed [MatW:0] omat_ff;
   logic [FracBits-1:0] tx_ff, ty_ff, tz_ff;

   // Effective dims: zero acts as one, above MaxDim as MaxDim.
   function automatic logic [DimW-1:0] eff(input logic [DimW-1:0] d);
      logic [DimW-1:0] r;
      r = d;
      if (d == '0) r = DimW'(1);
      else if (int'(d) > MaxDim) r = DimW'(MaxDim);
      return r;
   endfunction

   function automatic logic [IdxW-1:0] clampi(input logic signed [PW-FracBits:0] v,
                                             input logic [DimW-1:0] d);
      logic [IdxW-1:0] r;
      logic signed [PW-FracBits:0] hi;
      hi = $signed((PW-FracBits+1)'(d) - (PW-FracBits+1)'(1));
      if (v < 0) r = '0;
      else if (v > hi) r = IdxW'(hi);
      else r = IdxW'(v);
      return r;
   endfunction

   // Floor lerp: a + floor((b-a)*t / 2^FracBits); arithmetic shift floors.
   function automatic logic signed [DistW-1:0] lerp(input logic signed [DistW-1:0] a,
                                                     input logic signed [DistW-1:0] b,
                                                     input logic [FracBits-1:0] t);
      logic signed [DistW:0] df;
      logic signed [DistW+FracBits+1:0] pr;
      df = (DistW+1)'(b) - (DistW+1)'(a);
      pr = df * $signed({1'b0, t});
      return DistW'((DistW+FracBits+2)'(a) + (pr >>> FracBits));
   endfunction

   // Sample point offsets: 0 centre, 1/2 +-x, 3/4 +-y, 5/6 +-z.
   logic signed [PW-1:0] px, py, pz;
   always_comb begin
      px = $signed(PW'(cx_ff));
      py = $signed(PW'(cy_ff));
      pz = $signed(PW'(cz_ff));
      unique case (smp_ff)
         3'd1: px = px + One;
         3'd2: px = px - One;
         3'd3: py = py + One;
         3'd4: py = py - One;
         3'd5: pz = pz + One;
         3'd6: pz = pz - One;
         default: ;
      endcase
   end

   logic signed [PW-1:0] qx, qy, qz;
   logic signed [PW-FracBits:0] ix0, iy0, iz0;
   logic [IdxW-1:0] xs, ys, zs;
   assign qx = px + One;
   assign qy = py + One;
   assign qz = pz + One;
   assign ix0 = $signed({1'b0, qx[PW-1:FracBits]} - (PW-FracBits+1)'(1)
                        + (PW-FracBits+1)'(crn_ff[0]));
   assign iy0 = $signed({1'b0, qy[PW-1:FracBits]} - (PW-FracBits+1)'(1)
                        + (PW-FracBits+1)'(crn_ff[1]));
   assign iz0 = $signed({1'b0, qz[PW-1:FracBits]} - (PW-FracBits+1)'(1)
                        + (PW-FracBits+1)'(crn_ff[2]));
   assign xs = clampi(ix0, eff(dim_x_ff));
   assign ys = clampi(iy0, eff(dim_y_ff));
   assign zs = clampi(iz0, eff(dim_z_ff));

   logic [IdxW-1:0] mx, my, mz;
   assign mx = clampi((PW-FracBits+1)'(cx_ff[CoordW-1:FracBits]), eff(dim_x_ff));
   assign my = clampi((PW-FracBits+1)'(cy_ff[CoordW-1:FracBits]), eff(dim_y_ff));
   assign mz = clampi((PW-FracBits+1)'(cz_ff[CoordW-1:FracBits]), eff(dim_z_ff));

   assign rd_addr = (state_ff == ST_MAT) ? {mz, my, mx} : {zs, ys, xs};

   // Accept, write decode and query range check for the incoming transaction.
   logic accept, wr_ok, q_out;
   logic [CoordW-FracBits-1:0] wix, wiy, wiz;
   assign accept = req_valid && !req_stall;
   assign wix = req_coord_x[CoordW-1:FracBits];
   assign wiy = req_coord_y[CoordW-1:FracBits];
   assign wiz = req_coord_z[CoordW-1:FracBits];
   assign wr_ok = (wix < (CoordW-FracBits)'(eff(dim_x_ff)))
               && (wiy < (CoordW-FracBits)'(eff(dim_y_ff)))
               && (wiz < (CoordW-FracBits)'(eff(dim_z_ff)));
   assign q_out = (req_coord_x > CoordW'({eff(dim_x_ff), FracBits'(0)}))
               || (req_coord_y > CoordW'({eff(dim_y_ff), FracBits'(0)}))
               || (req_coord_z > CoordW'({eff(dim_z_ff), FracBits'(0)}));

   always_ff @(posedge clock) begin
      if (accept && opcode_type'(req_opcode) == OP_WRITE && wr_ok) begin
         dist_mem[{wiz[IdxW-1:0], wiy[IdxW-1:0], wix[IdxW-1:0]}] <= req_write_distance;
         mat_mem[{wiz[IdxW-1:0], wiy[IdxW-1:0], wix[IdxW-1:0]}] <= req_write_material;
      end
      rd_data_ff <= dist_mem[rd_addr];
      mat_data_ff <= mat_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_x_ff <= DimW'(32);
         dim_y_ff <= DimW'(32);
         dim_z_ff <= DimW'(32);
      end else if (csr_write_enable) begin
         if (csr_index == REG_DIM_X) dim_x_ff <= csr_write_data;
         if (csr_index == REG_DIM_Y) dim_y_ff <= csr_write_data;
         if (csr_index == REG_DIM_Z) dim_z_ff <= csr_write_data;
      end
   end

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      smp_in = smp_ff;
      crn_in = crn_ff;
      stp_in = stp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && opcode_type'(req_opcode) == OP_QUERY && !q_out) begin
               state_in = ST_READ;
               smp_in = '0;
               crn_in = '0;
            end
         end
         ST_READ: begin
            crn_in = crn_ff + 3'd1;
            if (crn_ff == 3'd7) begin
               state_in = ST_LERP;
               stp_in = '0;
            end
         end
         ST_LERP: begin
            // step 0 captures the last corner, then three lerp levels
            stp_in = stp_ff + 3'd1;
            if (stp_ff == 3'd3) begin
               crn_in = '0;
               if (smp_ff == 3'd6) begin
                  state_in = ST_MAT;
                  stp_in = '0;
               end else begin
                  smp_in = smp_ff + 3'd1;
                  state_in = ST_READ;
               end
            end
         end
         ST_MAT: begin
            stp_in = stp_ff + 3'd1;
            if (stp_ff == 3'd5) state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         smp_ff <= '0;
         crn_ff <= '0;
         stp_ff <= '0;
         rd_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         smp_ff <= smp_in;
         crn_ff <= crn_in;
         stp_ff <= stp_in;
         rd_pend_ff <= (state_ff == ST_READ);
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if ((state_ff == ST_IDLE && accept && opcode_type'(req_opcode) == OP_QUERY
              && q_out) || state_ff == ST_DONE)
            rsp_valid_ff <= 1'b1;
      end
   end

   // Datapath registers.
   logic signed [SmpW-1:0] sv;
   assign sv = SmpW'(lv_ff[6]);
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && accept) begin
         cx_ff <= req_coord_x;
         cy_ff <= req_coord_y;
         cz_ff <= req_coord_z;
         vres_ff <= 1'b0;
         odist_ff <= DistW'(32767);
         ogx_ff <= '0;
         ogy_ff <= '0;
         ogz_ff <= '0;
         omat_ff <= '1;
      end
      if (state_ff == ST_READ && crn_ff == 3'd0) begin
         tx_ff <= qx[FracBits-1:0];
         ty_ff <= qy[FracBits-1:0];
         tz_ff <= qz[FracBits-1:0];
      end
      if (rd_pend_ff) crn_val_ff[crn_ff - 3'd1] <= $signed(rd_data_ff);
      if (state_ff == ST_LERP) begin
         unique case (stp_ff)
            3'd1: begin
               lv_ff[0] <= lerp(crn_val_ff[0], crn_val_ff[1], tx_ff);
               lv_ff[1] <= lerp(crn_val_ff[2], crn_val_ff[3], tx_ff);
               lv_ff[2] <= lerp(crn_val_ff[4], crn_val_ff[5], tx_ff);
               lv_ff[3] <= lerp(crn_val_ff[6], crn_val_ff[7], tx_ff);
            end
            3'd2: begin
               lv_ff[4] <= lerp(lv_ff[0], lv_ff[1], ty_ff);
               lv_ff[5] <= lerp(lv_ff[2], lv_ff[3], ty_ff);
            end
            3'd3: lv_ff[6] <= lerp(lv_ff[4], lv_ff[5], tz_ff);
            default: ;
         endcase
      end
      if (state_ff == ST_LERP && stp_ff == 3'd0 && smp_ff != 3'd0) begin
         // previous sample is final here: fold into result
         unique case (smp_ff)
            3'd1: s0_ff <= sv;
            3'd2: sa_ff <= sv;
            3'd3: ga_ff <= sa_ff - sv;
            3'd4: sa_ff <= sv;
            3'd5: gb_ff <= sa_ff - sv;
            3'd6: sa_ff <= sv;
            default: ;
         endcase
      end
      if (state_ff == ST_MAT && stp_ff == 3'd0) gc_ff <= sa_ff - sv;
      if (state_ff == ST_MAT && stp_ff == 3'd3) begin
         vres_ff <= 1'b1;
         odist_ff <= DistW'(s0_ff);
         ogx_ff <= GradW'(ga_ff);
         ogy_ff <= GradW'(gb_ff);
         ogz_ff <= GradW'(gc_ff);
         omat_ff <= {1'b0, mat_data_ff};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_valid_res = vres_ff;
   assign rsp_distance = odist_ff;
   assign rsp_grad_x = ogx_ff;
   assign rsp_grad_y = ogy_ff;
   assign rsp_grad_z = ogz_ff;
   assign rsp_material = omat_ff;
endmodule

>>> rtl/vsdf_checker.sv
// Port-level checks for the voxel signed-distance query core.
// Depends on vsdf_pkg; bound to the top level below.
module vsdf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_valid_res,
   input logic signed [15:0] rsp_distance,
   input logic signed [8:0] rsp_material
);
   import vsdf_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_distance))
      else $error("stalled result transaction changed");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while result pending");
   a_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_material == -9'sd1)
      else $error("invalid result without material marker");
endmodule

bind voxel_sdf_trilinear_gradient_query_core vsdf_checker u_vsdf_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_valid_res(rsp_valid_res),
   .rsp_distance(rsp_distance), .rsp_material(rsp_material));
